FILE: rtl/core/sdbrs_pkg.sv
// ----------------------------------------------------------------------------
// Sector dirty bitmap range set: shared package
// Constants, result codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package sdbrs_pkg;

  localparam int OFF_W    = 48;
  localparam int LEN_W    = 32;
  localparam int SUM_W    = OFF_W + 1;
  localparam int SHIFT_W  = 4;
  localparam int LOWCHK_W = 16;
  localparam int STATUS_W = 2;

  localparam int WORD_BITS = 64;
  localparam int WORD_LOG2 = $clog2(WORD_BITS);

  localparam longint unsigned SECTOR_CAPACITY_DEF = 64'd1048576;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic CFG_IDX_SECTOR_LOG2 = 1'b0;
  localparam logic [SHIFT_W-1:0] SECTOR_LOG2_RST = 4'd9;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISALIGN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BEYOND   = 2'd2;

  typedef struct packed {
    logic load;
    logic check;
    logic range_chk;
    logic walk_init;
    logic rd;
    logic wr_step;
    logic clr_step;
  } sdbrs_cmd_t;

  typedef struct packed {
    logic misalign;
    logic beyond;
    logic empty;
    logic word_last;
    logic clr_last;
  } sdbrs_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/sdbrs_ram.sv
// ----------------------------------------------------------------------------
// Sector dirty bitmap range set: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sdbrs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/core/sdbrs_dp.sv
// ----------------------------------------------------------------------------
// Sector dirty bitmap range set: datapath
// Request checks, sector range and word walk over the bitmap memory.
// ----------------------------------------------------------------------------
`default_nettype none

module sdbrs_dp #(
  parameter longint unsigned SECTOR_CAPACITY = sdbrs_pkg::SECTOR_CAPACITY_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire sdbrs_pkg::sdbrs_cmd_t               cmd,
  output sdbrs_pkg::sdbrs_stat_t                   stat,
  input  wire logic [sdbrs_pkg::SHIFT_W-1:0]       sector_size_log2,
  input  wire logic [sdbrs_pkg::OFF_W-1:0]         byte_offset,
  input  wire logic [sdbrs_pkg::LEN_W-1:0]         byte_length
);

  import sdbrs_pkg::*;

  localparam longint unsigned MAP_DEPTH = (SECTOR_CAPACITY + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int SEC_W  = $clog2(SECTOR_CAPACITY + 1);

  logic [OFF_W-1:0]     off_r;
  logic [LEN_W-1:0]     len_r;
  logic [SUM_W-1:0]     sum_r;
  logic [SEC_W-1:0]     first_r;
  logic [SEC_W-1:0]     stop_r;
  logic                 misalign_r;
  logic                 beyond_r;
  logic                 empty_r;
  logic [ADDR_W-1:0]    cur_w_r;
  logic [ADDR_W-1:0]    first_w_r;
  logic [ADDR_W-1:0]    last_w_r;
  logic [WORD_LOG2-1:0] first_b_r;
  logic [WORD_LOG2-1:0] last_b_r;

  logic [LOWCHK_W-1:0]  low_mask;
  logic [OFF_W-1:0]     first_full;
  logic [SUM_W-1:0]     stop_full;
  logic [SEC_W-1:0]     last_sec;
  logic [WORD_LOG2-1:0] lo_bit;
  logic [WORD_LOG2-1:0] hi_bit;
  logic [WORD_BITS-1:0] ones;
  logic [WORD_BITS-1:0] word_mask;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] wdata;
  logic                 we;

  assign low_mask   = (LOWCHK_W'(1) << sector_size_log2) - LOWCHK_W'(1);
  assign first_full = off_r >> sector_size_log2;
  assign stop_full  = sum_r >> sector_size_log2;
  assign last_sec   = stop_r - SEC_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      off_r <= byte_offset;
      len_r <= byte_length;
    end
    if (cmd.check) begin
      misalign_r <= ((off_r[LOWCHK_W-1:0] & low_mask) != '0) ||
                    ((len_r[LOWCHK_W-1:0] & low_mask) != '0);
      sum_r      <= SUM_W'(off_r) + SUM_W'(len_r);
      first_r    <= first_full[SEC_W-1:0];
    end
    if (cmd.range_chk) begin
      beyond_r <= stop_full > SUM_W'(SECTOR_CAPACITY);
      stop_r   <= stop_full[SEC_W-1:0];
      empty_r  <= stop_full[SEC_W-1:0] == first_r;
    end
    if (cmd.walk_init) begin
      first_w_r <= first_r[ADDR_W+WORD_LOG2-1:WORD_LOG2];
      first_b_r <= first_r[WORD_LOG2-1:0];
      last_w_r  <= last_sec[ADDR_W+WORD_LOG2-1:WORD_LOG2];
      last_b_r  <= last_sec[WORD_LOG2-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_w_r <= '0;
    end else if (cmd.walk_init) begin
      cur_w_r <= first_r[ADDR_W+WORD_LOG2-1:WORD_LOG2];
    end else if (cmd.wr_step || cmd.clr_step) begin
      cur_w_r <= cur_w_r + ADDR_W'(1);
    end
  end

  assign ones      = '1;
  assign lo_bit    = (cur_w_r == first_w_r) ? first_b_r : '0;
  assign hi_bit    = (cur_w_r == last_w_r) ? last_b_r : WORD_LOG2'(WORD_BITS - 1);
  assign word_mask = (ones << lo_bit) & (ones >> (WORD_LOG2'(WORD_BITS - 1) - hi_bit));

  assign we    = cmd.wr_step || cmd.clr_step;
  assign wdata = cmd.clr_step ? '0 : (rdata | word_mask);

  sdbrs_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (int'(MAP_DEPTH))
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (cur_w_r),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (cur_w_r),
    .rdata (rdata)
  );

  assign stat.misalign  = misalign_r;
  assign stat.beyond    = beyond_r;
  assign stat.empty     = empty_r;
  assign stat.word_last = cur_w_r == last_w_r;
  assign stat.clr_last  = cur_w_r == ADDR_W'(MAP_DEPTH - 1);

endmodule

`default_nettype wire

FILE: rtl/core/sdbrs_ctrl.sv
// ----------------------------------------------------------------------------
// Sector dirty bitmap range set: controller
// Sequences the clearing pass, request checks and the word walk.
// ----------------------------------------------------------------------------
`default_nettype none

module sdbrs_ctrl (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  output sdbrs_pkg::sdbrs_cmd_t                   cmd,
  input  wire sdbrs_pkg::sdbrs_stat_t             stat,
  output logic                                    out_valid,
  output logic [sdbrs_pkg::STATUS_W-1:0]          out_status
);

  import sdbrs_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_RANGE  = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;
  localparam logic [2:0] S_WRITE  = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  always_comb begin
    cmd            = '0;
    state_nxt      = state_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = S_RANGE;
      end
      S_RANGE: begin
        cmd.range_chk = 1'b1;
        state_nxt     = S_DECIDE;
      end
      S_DECIDE: begin
        priority if (stat.misalign) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_MISALIGN;
          state_nxt      = S_IDLE;
        end else if (stat.beyond) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_BEYOND;
          state_nxt      = S_IDLE;
        end else if (stat.empty) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end else begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.wr_step = 1'b1;
        if (stat.word_last) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
  end

  assign busy       = state_r != S_IDLE;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

FILE: rtl/core/sector_dirty_bitmap_range_set_unit.sv
// ----------------------------------------------------------------------------
// Sector dirty bitmap range set unit
// Checks a disk write request for sector alignment and capacity and marks
// every covered sector as dirty in a flat bitmap memory.
//
//   Channel   Ports                                    Word
//   input     start, busy, in_byte_offset, in_byte_length  one write request
//   result    out_valid, out_status                    one request status
//   config    psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// A rejected request or one of zero length passes through the load, check,
// range and decide states before the next acceptance; a marked request then
// also reads and then writes each bitmap word that it covers, through the
// single write port of the bitmap memory.
// After reset the bitmap is cleared one word per cycle, which keeps busy high
// until all words are clear: ceil(SECTOR_CAPACITY / 64), 16384 by default.
// The status strobe lasts one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
`default_nettype none

module sector_dirty_bitmap_range_set_unit #(
  parameter longint unsigned SECTOR_CAPACITY = sdbrs_pkg::SECTOR_CAPACITY_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [sdbrs_pkg::OFF_W-1:0]          in_byte_offset,
  input  wire logic [sdbrs_pkg::LEN_W-1:0]          in_byte_length,
  output logic                                      out_valid,
  output logic [sdbrs_pkg::STATUS_W-1:0]            out_status,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [sdbrs_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [sdbrs_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [sdbrs_pkg::CFG_DATA_W-1:0]          prdata,
  output logic                                      pready
);

  import sdbrs_pkg::*;

  logic [SHIFT_W-1:0] sector_size_log2_r;
  logic               sel_log2;
  sdbrs_cmd_t         cmd;
  sdbrs_stat_t        stat;

  assign sel_log2 = paddr[CFG_ADDR_W-1] == CFG_IDX_SECTOR_LOG2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_size_log2_r <= SECTOR_LOG2_RST;
    end else if (psel && penable && pwrite && pready && sel_log2) begin
      sector_size_log2_r <= pwdata[SHIFT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = sel_log2 ? CFG_DATA_W'(sector_size_log2_r) : '0;

  sdbrs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_status (out_status)
  );

  sdbrs_dp #(
    .SECTOR_CAPACITY (SECTOR_CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .sector_size_log2 (sector_size_log2_r),
    .byte_offset      (in_byte_offset),
    .byte_length      (in_byte_length)
  );

endmodule

`default_nettype wire

FILE: bench/tb_sector_dirty_bitmap_range_set_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the sector dirty bitmap range set unit
// Drives disk write requests through the command port and steps through
// several sector sizes over the APB-style register port. A scoreboard
// predicts each request's status and keeps its own copy of the dirty bitmap.
// Each status word is checked against the oldest prediction. Requests are
// mostly well-formed ranges with random placement, mixed with ranges near the
// capacity limit, misaligned requests and raw noise.
// ----------------------------------------------------------------------------

import sdbrs_pkg::*;

class status_board;
  bit [SHIFT_W-1:0]      sector_log2;
  logic [STATUS_W-1:0]   status_due[$];
  bit [WORD_BITS-1:0]    dirty_words[int unsigned];
  int unsigned           fails;
  int unsigned           seen_ok;
  int unsigned           seen_misalign;
  int unsigned           seen_beyond;

  function new();
    sector_log2 = SECTOR_LOG2_RST;
  endfunction

  function void set_sector_log2(bit [SHIFT_W-1:0] value);
    sector_log2 = value;
  endfunction

  function int pending();
    return status_due.size();
  endfunction

  function void mark_range(longint unsigned first, longint unsigned stop);
    longint unsigned w, w_first, w_last;
    int lo, hi;
    bit [WORD_BITS-1:0] ones, mask;
    if (stop <= first) return;
    ones = '1;
    w_first = first / WORD_BITS;
    w_last = (stop - 1) / WORD_BITS;
    for (w = w_first; w <= w_last; w++) begin
      lo = (w == w_first) ? int'(first % WORD_BITS) : 0;
      hi = (w == w_last) ? int'((stop - 1) % WORD_BITS) : WORD_BITS - 1;
      mask = (ones >> (WORD_BITS - 1 - hi)) & (ones << lo);
      if (dirty_words.exists(32'(w))) dirty_words[32'(w)] = dirty_words[32'(w)] | mask;
      else dirty_words[32'(w)] = mask;
    end
  endfunction

  function void note_request(bit [OFF_W-1:0] offset, bit [LEN_W-1:0] length);
    longint unsigned low, first, stop;
    low = (64'd1 << sector_log2) - 1;
    if (((64'(offset) & low) != 0) || ((64'(length) & low) != 0)) begin
      status_due.push_back(ST_MISALIGN);
      seen_misalign++;
      return;
    end
    first = 64'(offset) >> sector_log2;
    stop = (64'(offset) + 64'(length)) >> sector_log2;
    if (stop > SECTOR_CAPACITY_DEF) begin
      status_due.push_back(ST_BEYOND);
      seen_beyond++;
      return;
    end
    mark_range(first, stop);
    status_due.push_back(ST_OK);
    seen_ok++;
  endfunction

  function void check_status(logic [STATUS_W-1:0] got);
    logic [STATUS_W-1:0] want;
    if (status_due.size() == 0) begin
      $error("status word with no request pending: status actual %0d", got);
      fails++;
      return;
    end
    want = status_due.pop_front();
    if (got !== want) begin
      $error("status mismatch: expected %0d, actual %0d", want, got);
      fails++;
    end
  endfunction
endclass

module tb_sector_dirty_bitmap_range_set_unit;

  localparam int unsigned SECTOR_CAP = 32'(SECTOR_CAPACITY_DEF);
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int PHASES = 7;
  localparam int RANDOM_PER_PHASE = 78;
  localparam bit [SHIFT_W-1:0] SIZE_PLAN [PHASES] = '{4'd9, 4'd12, 4'd0, 4'd15, 4'd10, 4'd11,
                                                      4'd13};
  localparam logic [CFG_ADDR_W-1:0] SECTOR_LOG2_ADDR = {CFG_IDX_SECTOR_LOG2, 2'b00};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [OFF_W-1:0]      in_byte_offset = '0;
  logic [LEN_W-1:0]      in_byte_length = '0;
  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  status_board board = new();
  int unsigned cycle_count = 0;

  sector_dirty_bitmap_range_set_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_byte_offset (in_byte_offset),
    .in_byte_length (in_byte_length),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_status(out_status);
  end

  task automatic send_request(input bit [OFF_W-1:0] offset, input bit [LEN_W-1:0] length);
    in_byte_offset <= offset;
    in_byte_length <= length;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    board.note_request(offset, length);
  endtask

  task automatic maybe_pause(input bit quiet);
    int unsigned gap;
    if (quiet || $urandom_range(99) >= 28) return;
    gap = ($urandom_range(3) == 0) ? $urandom_range(30, 8) : $urandom_range(6, 1);
    start <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (board.pending() != 0 || busy) @(posedge clk);
  endtask

  task automatic program_sector_size(input bit [SHIFT_W-1:0] value);
    logic [CFG_DATA_W-1:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SECTOR_LOG2_ADDR;
    pwdata <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_sector_log2(value);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== CFG_DATA_W'(value)) begin
      $error("sector_size_log2 readback mismatch: expected %0d, actual %0d", value, got);
      board.fails++;
    end
  endtask

  task automatic pick_request(input bit [SHIFT_W-1:0] sh, output bit [OFF_W-1:0] offset,
                              output bit [LEN_W-1:0] length);
    int unsigned pick, n;
    longint unsigned first, low;
    low = (64'd1 << sh) - 1;
    pick = $urandom_range(99);
    if (pick < 55) begin
      n = ($urandom_range(3) == 0) ? $urandom_range(700) : $urandom_range(64);
      first = $urandom_range(SECTOR_CAP - n);
      offset = OFF_W'(first << sh);
      length = LEN_W'(n << sh);
    end else if (pick < 65) begin
      n = $urandom_range(130);
      first = SECTOR_CAP + 64 - $urandom_range(200);
      offset = OFF_W'(first << sh);
      length = LEN_W'(n << sh);
    end else if (pick < 78) begin
      n = $urandom_range(64);
      first = $urandom_range(SECTOR_CAP - n);
      offset = OFF_W'(first << sh);
      length = LEN_W'(n << sh);
      if (low != 0) begin
        case ($urandom_range(2))
          0: offset = offset | OFF_W'($urandom_range(32'(low), 1));
          1: length = length | LEN_W'($urandom_range(32'(low), 1));
          default: begin
            offset = offset | OFF_W'($urandom_range(32'(low), 1));
            length = length | LEN_W'($urandom_range(32'(low), 1));
          end
        endcase
      end
    end else if (pick < 90) begin
      offset = OFF_W'({$urandom, $urandom});
      length = $urandom;
    end else begin
      offset = (OFF_W'({$urandom, $urandom}) >> sh) << sh;
      length = ($urandom >> sh) << sh;
    end
  endtask

  initial begin
    int phase, k;
    bit [OFF_W-1:0] offset;
    bit [LEN_W-1:0] length;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (!busy);
    wait_idle();

    for (phase = 0; phase < PHASES; phase++) begin
      program_sector_size(SIZE_PLAN[phase]);
      if (phase == 0) begin
        send_request(48'h0, 32'h0);                          maybe_pause(1'b0);
        send_request(48'h0, 32'h200);                        maybe_pause(1'b0);
        send_request(48'h0, 32'h8000);                       maybe_pause(1'b0);
        send_request(48'h7E00, 32'h400);                     maybe_pause(1'b0);
        send_request(48'h1, 32'h200);                        maybe_pause(1'b0);
        send_request(48'h0, 32'h1);                          maybe_pause(1'b0);
        send_request(48'h0, 32'hFFFF_FFFF);                  maybe_pause(1'b0);
        send_request(48'hFFFF_FFFF_FFFF, 32'h0);             maybe_pause(1'b0);
        send_request(48'h1FFF_FE00, 32'h200);                maybe_pause(1'b0);
        send_request(48'h2000_0000, 32'h0);                  maybe_pause(1'b0);
        send_request(48'h2000_0200, 32'h0);                  maybe_pause(1'b0);
        send_request(48'h1FFF_FE00, 32'h400);                maybe_pause(1'b0);
        send_request(48'hFFFF_FFFF_FE00, 32'h0);             maybe_pause(1'b0);
        send_request(48'h0, 32'hFFFF_FE00);                  maybe_pause(1'b0);
        send_request(48'h0, 32'h2000_0000);                  maybe_pause(1'b0);
        send_request(48'hA00, 32'h1_9000);                   maybe_pause(1'b0);
        send_request(48'hE00, 32'h600);                      maybe_pause(1'b0);
        send_request(48'h1FFF_0000, 32'h1_0000);             maybe_pause(1'b0);
        send_request(48'h8000_0000_0000, 32'h8000_0000);     maybe_pause(1'b0);
      end
      for (k = 0; k < RANDOM_PER_PHASE; k++) begin
        pick_request(SIZE_PLAN[phase], offset, length);
        send_request(offset, length);
        if (phase == 1 && k == 40) wait_idle();
        else maybe_pause(phase == 3);
      end
      wait_idle();
    end

    repeat (8) @(posedge clk);
    $display("Ran %0d requests over %0d sector sizes: %0d marked, %0d misaligned, %0d past capacity.",
             board.seen_ok + board.seen_misalign + board.seen_beyond, PHASES, board.seen_ok,
             board.seen_misalign, board.seen_beyond);
    $display("The predicted bitmap holds %0d words with dirty sectors.", board.dirty_words.num());
    if (board.fails == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
